>>> src/ocrp_pkg.sv
// Package for the colour reply parser: phase encoding, byte codes, result bundle
// and the helper functions for hex decoding, key spelling and component scaling.
// No dependencies.
package ocrp_pkg;

    typedef enum logic [14:0] {
        PH_IDLE   = 15'h0001,
        PH_ESC    = 15'h0002,
        PH_BODY   = 15'h0004,
        PH_K4     = 15'h0008,
        PH_K1     = 15'h0010,
        PH_K1X    = 15'h0020,
        PH_K2     = 15'h0040,
        PH_K21    = 15'h0080,
        PH_IDX0   = 15'h0100,
        PH_IDXN   = 15'h0200,
        PH_PKEY   = 15'h0400,
        PH_PSKIP  = 15'h0800,
        PH_PREFIX = 15'h1000,
        PH_HASH   = 15'h2000,
        PH_COMP   = 15'h4000
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [4:0] slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

    localparam logic [7:0] ChNul     = 8'h00;
    localparam logic [7:0] ChEsc     = 8'h1b;
    localparam logic [7:0] ChBracket = 8'h5d;
    localparam logic [7:0] ChSemi    = 8'h3b;
    localparam logic [7:0] ChSlash   = 8'h2f;
    localparam logic [7:0] ChHash    = 8'h23;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChOne     = 8'h31;
    localparam logic [7:0] ChTwo     = 8'h32;
    localparam logic [7:0] ChFour    = 8'h34;
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChLowB    = 8'h62;
    localparam logic [7:0] ChLowF    = 8'h66;

    localparam logic [4:0] SlotFg = 5'd16;
    localparam logic [4:0] SlotBg = 5'd17;
    localparam logic [4:0] IdxMax = 5'd31;

    localparam logic [3:0] KeyLen = 4'd11;
    localparam logic [3:0] RgbLen = 4'd4;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // "background=" or "foreground="
    function automatic logic [7:0] key_char(input logic bg, input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = bg ? 8'h62 : 8'h66;
            4'd1:    c = bg ? 8'h61 : 8'h6f;
            4'd2:    c = bg ? 8'h63 : 8'h72;
            4'd3:    c = bg ? 8'h6b : 8'h65;
            4'd4:    c = 8'h67;
            4'd5:    c = 8'h72;
            4'd6:    c = 8'h6f;
            4'd7:    c = 8'h75;
            4'd8:    c = 8'h6e;
            4'd9:    c = 8'h64;
            4'd10:   c = 8'h3d;
            default: c = ChNul;
        endcase
        return c;
    endfunction

    // "rgb:"
    function automatic logic [7:0] rgb_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h72;
            4'd1:    c = 8'h67;
            4'd2:    c = 8'h62;
            4'd3:    c = 8'h3a;
            default: c = ChNul;
        endcase
        return c;
    endfunction

    // round(v * 255 / (16^n - 1)); divide by 2^k-1 via (x + (x >> k) + 1) >> k
    function automatic logic [7:0] scale(input logic [15:0] v, input logic [2:0] n);
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] q;
        logic [7:0]  r;
        x = {v, 8'h00} - {8'h00, v};
        y = 24'd0;
        q = 24'd0;
        unique case (n)
            3'd1: r = {v[3:0], v[3:0]};
            3'd2: r = v[7:0];
            3'd3: begin
                y = x + 24'd2047;
                q = (y + (y >> 12) + 24'd1) >> 12;
                r = q[7:0];
            end
            3'd4: begin
                y = x + 24'd32767;
                q = (y + (y >> 16) + 24'd1) >> 16;
                r = q[7:0];
            end
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/osc_colour_reply_parser_core.sv
// Top level of the colour reply parser: input register, parser, result register.
// Depends on ocrp_pkg and ocrp_parser.
//
// Use: feed terminal reply bytes on the input channel (i_in_valid / o_in_stall,
// payload i_reply_byte and i_end_of_buffer). Each colour found in an
// ESC ] 4;n; / 10; / 11; / 21; reply leaves as one transfer on the output
// channel (o_out_valid / i_out_stall, payload o_slot, o_red, o_green, o_blue).
// A result is registered in the result register when the parser steps the byte
// that completes it out of the input register; a stalled result can hold it there.
// Throughput: one byte per cycle while no result is stalled, set by the
// combinational parser step between the input register and the result register.
// Reset clears the parser to idle and empties both registers. A NUL byte or
// a byte flagged as the last one stops the parser; later bytes are taken and
// dropped until the next reset. When the receiver stalls a waiting result,
// the input register still fills; further bytes are stalled only while a
// byte waits behind the held result.
module osc_colour_reply_parser_core import ocrp_pkg::*; #(
    parameter int PALETTE_SIZE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_reply_byte,
    input  logic       i_end_of_buffer,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_slot,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eob;
    logic       r_out_valid;
    logic [4:0] r_slot;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic       w_adv;
    logic       w_take;
    t_result    w_result;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign w_take     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !w_adv;

    ocrp_parser #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_byte   (r_in_byte),
        .i_eob    (r_in_eob),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_reply_byte;
            r_in_eob  <= i_end_of_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_slot  <= w_result.slot;
            r_red   <= w_result.red;
            r_green <= w_result.green;
            r_blue  <= w_result.blue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot      = r_slot;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

endmodule

>>> src/ocrp_parser.sv
// Byte parser state and next-state logic for the colour reply parser.
// Depends on ocrp_pkg; one byte is consumed per enabled cycle.
module ocrp_parser import ocrp_pkg::*; #(
    parameter int PALETTE_SIZE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_eob,
    output t_result    o_result
);

    localparam logic [4:0] PalLimit = 5'(PALETTE_SIZE);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_kp, n_kp;
    logic [4:0]  r_idx, n_idx;
    logic [4:0]  r_slot, n_slot;
    logic [1:0]  r_comp, n_comp;
    logic [2:0]  r_cnt, n_cnt;
    logic [15:0] r_acc, n_acc;
    logic [7:0]  r_red, n_red;
    logic [7:0]  r_green, n_green;
    logic        r_stopped, n_stopped;
    logic        r_in21, n_in21;

    logic [4:0]  w_hex;
    logic [3:0]  w_d;
    logic        w_is_hex;
    logic        w_is_dec;
    logic        w_append;
    logic [15:0] w_acc_app;
    logic [2:0]  w_cnt_inc;
    logic [7:0]  w_scaled;
    logic        w_finish_old;
    logic [8:0]  w_idx_base;
    logic [8:0]  w_idx_mul;
    logic [4:0]  w_idx_sat;
    logic [7:0]  w_hash_v;
    t_phase      w_after_b;
    t_phase      w_after_0;
    logic        w_emit;
    logic [7:0]  w_blue;

    assign w_hex     = hex_digit(i_byte);
    assign w_is_hex  = w_hex[4];
    assign w_d       = w_hex[3:0];
    assign w_is_dec  = (i_byte >= ChZero) && (i_byte <= ChNine);
    assign w_append  = (r_phase == PH_COMP) && w_is_hex && (r_cnt < 3'd4);
    assign w_acc_app = {r_acc[11:0], w_d};
    assign w_cnt_inc = r_cnt + 3'd1;
    assign w_scaled  = w_append ? scale(w_acc_app, w_cnt_inc) : scale(r_acc, r_cnt);
    assign w_finish_old = (r_phase == PH_COMP) && (r_comp == 2'd2) &&
                          (r_cnt >= 3'd1) && (r_cnt <= 3'd4);
    assign w_idx_base = (r_phase == PH_IDX0) ? 9'd0 : {4'd0, r_idx};
    assign w_idx_mul  = (w_idx_base << 3) + (w_idx_base << 1) + {5'd0, i_byte[3:0]};
    assign w_idx_sat  = (w_idx_mul > {4'd0, IdxMax}) ? IdxMax : w_idx_mul[4:0];
    assign w_hash_v   = {r_acc[3:0], w_d};
    assign w_after_b  = r_in21 ? ((i_byte == ChSemi) ? PH_PKEY : PH_PSKIP) : PH_IDLE;
    assign w_after_0  = r_in21 ? PH_PSKIP : PH_IDLE;

    always_comb begin
        n_phase   = r_phase;
        n_kp      = r_kp;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_comp    = r_comp;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_red     = r_red;
        n_green   = r_green;
        n_stopped = r_stopped;
        n_in21    = r_in21;
        w_emit    = 1'b0;
        w_blue    = w_scaled;
        if (i_en && !r_stopped) begin
            if (i_byte == ChNul) begin
                w_emit    = w_finish_old;
                n_phase   = PH_IDLE;
                n_stopped = 1'b1;
            end else if (i_byte == ChEsc) begin
                w_emit    = w_finish_old;
                n_phase   = PH_ESC;
                n_stopped = i_eob;
            end else begin
                unique case (r_phase)
                    PH_ESC: begin
                        n_phase = (i_byte == ChBracket) ? PH_BODY : PH_IDLE;
                    end
                    PH_BODY: begin
                        if (i_byte == ChFour) n_phase = PH_K4;
                        else if (i_byte == ChOne) n_phase = PH_K1;
                        else if (i_byte == ChTwo) n_phase = PH_K2;
                        else n_phase = PH_IDLE;
                    end
                    PH_K4: begin
                        if (i_byte == ChSemi) begin
                            n_phase = PH_IDX0;
                            n_idx   = 5'd0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_K1: begin
                        if (i_byte == ChZero) begin
                            n_slot  = SlotFg;
                            n_phase = PH_K1X;
                        end else if (i_byte == ChOne) begin
                            n_slot  = SlotBg;
                            n_phase = PH_K1X;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_K1X: begin
                        if (i_byte == ChSemi) begin
                            n_phase = PH_PREFIX;
                            n_in21  = 1'b0;
                            n_kp    = 4'd0;
                            n_comp  = 2'd0;
                            n_cnt   = 3'd0;
                            n_acc   = 16'd0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_K2: begin
                        n_phase = (i_byte == ChOne) ? PH_K21 : PH_IDLE;
                    end
                    PH_K21: begin
                        if (i_byte == ChSemi) begin
                            n_phase = PH_PKEY;
                            n_kp    = 4'd0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_IDX0, PH_IDXN: begin
                        if (w_is_dec) begin
                            n_idx   = w_idx_sat;
                            n_phase = PH_IDXN;
                        end else if (i_byte == ChSemi && r_phase == PH_IDXN &&
                                     r_idx < PalLimit) begin
                            n_slot  = r_idx;
                            n_phase = PH_PREFIX;
                            n_in21  = 1'b0;
                            n_kp    = 4'd0;
                            n_comp  = 2'd0;
                            n_cnt   = 3'd0;
                            n_acc   = 16'd0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_PKEY: begin
                        if (r_kp == 4'd0) begin
                            if (i_byte == ChLowB) begin
                                n_slot = SlotBg;
                                n_kp   = 4'd1;
                            end else if (i_byte == ChLowF) begin
                                n_slot = SlotFg;
                                n_kp   = 4'd1;
                            end else begin
                                n_phase = (i_byte == ChSemi) ? PH_PKEY : PH_PSKIP;
                                n_kp    = 4'd0;
                            end
                        end else if (r_kp < KeyLen &&
                                     i_byte == key_char(r_slot == SlotBg, r_kp)) begin
                            n_kp = r_kp + 4'd1;
                            if (n_kp == KeyLen) begin
                                n_phase = PH_PREFIX;
                                n_in21  = 1'b1;
                                n_kp    = 4'd0;
                                n_comp  = 2'd0;
                                n_cnt   = 3'd0;
                                n_acc   = 16'd0;
                            end
                        end else begin
                            n_phase = (i_byte == ChSemi) ? PH_PKEY : PH_PSKIP;
                            n_kp    = 4'd0;
                        end
                    end
                    PH_PSKIP: begin
                        if (i_byte == ChSemi) begin
                            n_phase = PH_PKEY;
                            n_kp    = 4'd0;
                        end
                    end
                    PH_PREFIX: begin
                        if (r_kp == 4'd0 && i_byte == ChHash) begin
                            n_phase = PH_HASH;
                        end else if (r_kp < RgbLen && i_byte == rgb_char(r_kp)) begin
                            n_kp = r_kp + 4'd1;
                            if (n_kp == RgbLen) n_phase = PH_COMP;
                        end else begin
                            n_phase = w_after_b;
                            n_kp    = 4'd0;
                        end
                    end
                    PH_HASH: begin
                        if (!w_is_hex) begin
                            n_phase = w_after_b;
                            n_kp    = 4'd0;
                        end else if (r_cnt == 3'd0) begin
                            n_acc = {12'd0, w_d};
                            n_cnt = 3'd1;
                        end else begin
                            n_cnt = 3'd0;
                            if (r_comp == 2'd0) begin
                                n_red  = w_hash_v;
                                n_comp = 2'd1;
                            end else if (r_comp == 2'd1) begin
                                n_green = w_hash_v;
                                n_comp  = 2'd2;
                            end else begin
                                w_emit  = 1'b1;
                                w_blue  = w_hash_v;
                                n_phase = w_after_0;
                                n_kp    = 4'd0;
                            end
                        end
                    end
                    PH_COMP: begin
                        if (w_append) begin
                            n_acc = w_acc_app;
                            n_cnt = w_cnt_inc;
                            if (r_comp >= 2'd2 && w_cnt_inc == 3'd4) begin
                                w_emit  = 1'b1;
                                n_phase = w_after_0;
                                n_kp    = 4'd0;
                            end
                        end else if (i_byte == ChSlash && r_comp < 2'd2 && r_cnt >= 3'd1) begin
                            if (r_comp == 2'd0) n_red = w_scaled;
                            else n_green = w_scaled;
                            n_comp = r_comp + 2'd1;
                            n_cnt  = 3'd0;
                            n_acc  = 16'd0;
                        end else begin
                            w_emit  = (r_comp >= 2'd2) && (r_cnt >= 3'd1) && (r_cnt <= 3'd4);
                            n_phase = w_after_b;
                            n_kp    = 4'd0;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                if (i_eob) begin
                    if (!w_emit && n_phase == PH_COMP && n_comp == 2'd2 &&
                        n_cnt >= 3'd1 && n_cnt <= 3'd4) begin
                        w_emit = 1'b1;
                    end
                    n_phase   = PH_IDLE;
                    n_stopped = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_kp      <= 4'd0;
            r_idx     <= 5'd0;
            r_slot    <= 5'd0;
            r_comp    <= 2'd0;
            r_cnt     <= 3'd0;
            r_acc     <= 16'd0;
            r_red     <= 8'd0;
            r_green   <= 8'd0;
            r_stopped <= 1'b0;
            r_in21    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_kp      <= n_kp;
            r_idx     <= n_idx;
            r_slot    <= n_slot;
            r_comp    <= n_comp;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_red     <= n_red;
            r_green   <= n_green;
            r_stopped <= n_stopped;
            r_in21    <= n_in21;
        end
    end

    assign o_result.valid = w_emit;
    assign o_result.slot  = r_slot;
    assign o_result.red   = r_red;
    assign o_result.green = r_green;
    assign o_result.blue  = w_blue;

endmodule

>>> src/ocrp_checker.sv
// Port-level checks for the colour reply parser, bound to the top level.
// Depends on osc_colour_reply_parser_core port names only.
module ocrp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [4:0] o_slot,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_slot <= 5'd17))
        else $error("result slot out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_slot) &&
            $stable(o_red) && $stable(o_green) && $stable(o_blue))
        else $error("stalled result changed");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a byte transfer two cycles before");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result path free");

endmodule

bind osc_colour_reply_parser_core ocrp_checker u_ocrp_checker (.*);

>>> verif/osc_colour_reply_parser_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for osc_colour_reply_parser_core: directed and random
// terminal reply bytes, colours predicted in-bench and checked per transfer.
// Depends on ocrp_pkg and the parser RTL.
module osc_colour_reply_parser_core_tb;
    import ocrp_pkg::*;

    localparam int PaletteSize = 16;
    localparam int WatchdogLimit = 1000;
    localparam int DrainCycles = 16;
    localparam int PhaseBytes = 350;

    localparam logic [87:0] BgName = "background=";
    localparam logic [87:0] FgName = "foreground=";
    localparam logic [31:0] RgbName = "rgb:";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_item;

    typedef struct packed {
        logic [4:0] slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_colour;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_reply_byte = 8'd0;
    logic       i_end_of_buffer = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [4:0] o_slot;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    t_reply_item pending_bytes[$];
    t_colour     colours_due[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_queued = 0;
    int bytes_sent = 0;
    int colours_seen = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    string hex_alphabet = "0123456789abcdefABCDEF";
    string junk_keys[5] = '{"backgroundx", "foreground", "fg=1", "x=rgb:1/2/3",
                            "backgrounx=#123456"};

    // parser shadow state
    t_phase      ph = PH_IDLE;
    logic        pair_mode = 1'b0;
    logic [3:0]  key_pos = 4'd0;
    logic [4:0]  index_acc = 5'd0;
    logic [4:0]  slot_sel = 5'd0;
    logic [1:0]  comp_idx = 2'd0;
    logic [2:0]  digit_cnt = 3'd0;
    logic [15:0] comp_acc = 16'd0;
    logic [7:0]  red_held = 8'd0;
    logic [7:0]  green_held = 8'd0;
    logic        halted = 1'b0;
    logic        colour_out = 1'b0;

    osc_colour_reply_parser_core #(
        .PALETTE_SIZE(PaletteSize)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_reply_byte   (i_reply_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_slot         (o_slot),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int hex_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") begin
            return int'(b - "0");
        end else if (b >= "a" && b <= "f") begin
            return int'(b - "a") + 10;
        end else if (b >= "A" && b <= "F") begin
            return int'(b - "A") + 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] round_to_byte(input logic [15:0] v, input logic [2:0] n);
        int unsigned m;
        m = (32'd1 << (4 * n)) - 1;
        return 8'((32'(v) * 255 + m / 2) / m);
    endfunction

    function automatic logic [7:0] name_char(input logic [87:0] name, input int pos);
        return name[87 - 8 * pos -: 8];
    endfunction

    task automatic emit_colour(input logic [7:0] blue);
        colours_due.push_back('{slot_sel, red_held, green_held, blue});
        colour_out = 1'b1;
    endtask

    task automatic flush_blue();
        if (ph == PH_COMP && comp_idx == 2 && digit_cnt >= 1 && digit_cnt <= 4) begin
            emit_colour(round_to_byte(comp_acc, digit_cnt));
        end
    endtask

    task automatic leave_colour(input logic pairs, input logic [7:0] b);
        if (pairs) begin
            ph = PH_PSKIP;
            if (b == ChSemi) begin
                ph = PH_PKEY;
                key_pos = 4'd0;
            end
        end else begin
            ph = PH_IDLE;
        end
    endtask

    task automatic begin_colour(input logic pairs);
        ph = PH_PREFIX;
        pair_mode = pairs;
        key_pos = 4'd0;
        comp_idx = 2'd0;
        digit_cnt = 3'd0;
        comp_acc = 16'd0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        int d;
        int v;
        logic [7:0] pair;
        d = hex_value(b);
        colour_out = 1'b0;
        if (halted) begin
        end else if (b == ChNul) begin
            flush_blue();
            ph = PH_IDLE;
            halted = 1'b1;
        end else if (b == ChEsc) begin
            flush_blue();
            ph = PH_ESC;
            if (last) halted = 1'b1;
        end else begin
            case (ph)
                PH_ESC: ph = (b == ChBracket) ? PH_BODY : PH_IDLE;
                PH_BODY: begin
                    if (b == ChFour) ph = PH_K4;
                    else if (b == ChOne) ph = PH_K1;
                    else if (b == ChTwo) ph = PH_K2;
                    else ph = PH_IDLE;
                end
                PH_K4: begin
                    if (b == ChSemi) begin
                        ph = PH_IDX0;
                        index_acc = 5'd0;
                    end else begin
                        ph = PH_IDLE;
                    end
                end
                PH_K1: begin
                    if (b == ChZero) begin
                        slot_sel = SlotFg;
                        ph = PH_K1X;
                    end else if (b == ChOne) begin
                        slot_sel = SlotBg;
                        ph = PH_K1X;
                    end else begin
                        ph = PH_IDLE;
                    end
                end
                PH_K1X: begin
                    if (b == ChSemi) begin_colour(1'b0);
                    else ph = PH_IDLE;
                end
                PH_K2: ph = (b == ChOne) ? PH_K21 : PH_IDLE;
                PH_K21: begin
                    if (b == ChSemi) begin
                        ph = PH_PKEY;
                        key_pos = 4'd0;
                    end else begin
                        ph = PH_IDLE;
                    end
                end
                PH_IDX0, PH_IDXN: begin
                    if (b >= ChZero && b <= ChNine) begin
                        v = (ph == PH_IDX0) ? 0 : int'(index_acc);
                        v = v * 10 + int'(b - ChZero);
                        index_acc = (v > int'(IdxMax)) ? IdxMax : 5'(v);
                        ph = PH_IDXN;
                    end else if (b == ChSemi && ph == PH_IDXN && index_acc < PaletteSize) begin
                        slot_sel = index_acc;
                        begin_colour(1'b0);
                    end else begin
                        ph = PH_IDLE;
                    end
                end
                PH_PKEY: begin
                    if (key_pos == 0) begin
                        if (b == ChLowB) begin
                            slot_sel = SlotBg;
                            key_pos = 4'd1;
                        end else if (b == ChLowF) begin
                            slot_sel = SlotFg;
                            key_pos = 4'd1;
                        end else begin
                            leave_colour(1'b1, b);
                        end
                    end else if (key_pos < KeyLen &&
                                 b == name_char(slot_sel == SlotBg ? BgName : FgName,
                                                key_pos)) begin
                        key_pos++;
                        if (key_pos == KeyLen) begin_colour(1'b1);
                    end else begin
                        leave_colour(1'b1, b);
                    end
                end
                PH_PSKIP: begin
                    if (b == ChSemi) begin
                        ph = PH_PKEY;
                        key_pos = 4'd0;
                    end
                end
                PH_PREFIX: begin
                    if (key_pos == 0 && b == ChHash) begin
                        ph = PH_HASH;
                    end else if (key_pos < RgbLen && b == name_char({RgbName, 56'd0}, key_pos)) begin
                        key_pos++;
                        if (key_pos == RgbLen) ph = PH_COMP;
                    end else begin
                        leave_colour(pair_mode, b);
                    end
                end
                PH_HASH: begin
                    if (d < 0) begin
                        leave_colour(pair_mode, b);
                    end else if (digit_cnt == 0) begin
                        comp_acc = 16'(d);
                        digit_cnt = 3'd1;
                    end else begin
                        pair = {comp_acc[3:0], 4'(d)};
                        digit_cnt = 3'd0;
                        if (comp_idx == 0) begin
                            red_held = pair;
                            comp_idx = 2'd1;
                        end else if (comp_idx == 1) begin
                            green_held = pair;
                            comp_idx = 2'd2;
                        end else begin
                            emit_colour(pair);
                            leave_colour(pair_mode, ChNul);
                        end
                    end
                end
                PH_COMP: begin
                    if (d >= 0 && digit_cnt < 4) begin
                        comp_acc = {comp_acc[11:0], 4'(d)};
                        digit_cnt++;
                        if (comp_idx == 2 && digit_cnt == 4) begin
                            emit_colour(round_to_byte(comp_acc, 3'd4));
                            leave_colour(pair_mode, ChNul);
                        end
                    end else if (b == ChSlash && comp_idx < 2 && digit_cnt >= 1) begin
                        if (comp_idx == 0) red_held = round_to_byte(comp_acc, digit_cnt);
                        else green_held = round_to_byte(comp_acc, digit_cnt);
                        comp_idx++;
                        digit_cnt = 3'd0;
                        comp_acc = 16'd0;
                    end else begin
                        if (comp_idx == 2 && digit_cnt >= 1) begin
                            emit_colour(round_to_byte(comp_acc, digit_cnt));
                        end
                        leave_colour(pair_mode, b);
                    end
                end
                default: ph = PH_IDLE;
            endcase
            if (last) begin
                if (!colour_out) flush_blue();
                ph = PH_IDLE;
                halted = 1'b1;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back('{b, 1'b0});
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_hex();
        return hex_alphabet[$urandom_range(21)];
    endfunction

    function automatic logic [7:0] rand_nonnul();
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic push_noise();
        repeat ($urandom_range(6, 1)) push_byte(rand_nonnul());
    endtask

    task automatic push_colour();
        int n;
        int c;
        if ($urandom_range(1)) begin
            push_text(($urandom_range(29) == 0) ? "rgb" : "rgb:");
            for (c = 0; c < 3; c++) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(5) : $urandom_range(4, 1);
                repeat (n) push_byte(rand_hex());
                if (c < 2) push_byte(ChSlash);
            end
        end else begin
            push_byte(ChHash);
            n = ($urandom_range(19) == 0) ? $urandom_range(7) : 6;
            repeat (n) push_byte(rand_hex());
        end
    endtask

    task automatic push_index();
        case ($urandom_range(7))
            0: push_text($sformatf("%0d", $urandom_range(999, PaletteSize)));
            1: push_text($sformatf("0%0d", $urandom_range(9)));
            2: push_text("65535123");
            3: ;
            default: push_text($sformatf("%0d", $urandom_range(PaletteSize - 1)));
        endcase
    endtask

    task automatic push_sequence();
        int k;
        push_byte(ChEsc);
        push_byte(($urandom_range(29) == 0) ? rand_nonnul() : ChBracket);
        case ($urandom_range(3))
            0: begin
                push_byte(ChFour);
                push_byte(ChSemi);
                push_index();
                push_byte(ChSemi);
                push_colour();
            end
            1: begin
                push_text("10;");
                push_colour();
            end
            2: begin
                push_text("11;");
                push_colour();
            end
            default: begin
                push_text("21;");
                for (k = $urandom_range(3, 1); k > 0; k--) begin
                    case ($urandom_range(4))
                        0, 1: begin
                            push_text("background=");
                            push_colour();
                        end
                        2, 3: begin
                            push_text("foreground=");
                            push_colour();
                        end
                        default: push_text(junk_keys[$urandom_range(4)]);
                    endcase
                    if (k > 1) push_byte(ChSemi);
                end
            end
        endcase
        case ($urandom_range(3))
            0: push_byte(ChSemi);
            1: push_byte(rand_nonnul());
            default: ;
        endcase
        if ($urandom_range(9) == 0) push_noise();
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : drive_bytes
        t_reply_item head;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_reply_byte, i_end_of_buffer);
                bytes_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    head = pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    i_reply_byte <= head.data;
                    i_end_of_buffer <= head.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_colours
        t_colour want;
        t_colour got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_slot, o_red, o_green, o_blue};
            colours_seen++;
            if (colours_due.size() == 0) begin
                report_mismatch($sformatf("unexpected colour: slot %0d rgb %02h %02h %02h",
                                          got.slot, got.red, got.green, got.blue));
            end else begin
                want = colours_due.pop_front();
                if (got.slot !== want.slot || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue) begin
                    report_mismatch($sformatf(
                        "colour %0d: expected slot %0d rgb %02h %02h %02h, got slot %0d rgb %02h %02h %02h",
                        colours_seen, want.slot, want.red, want.green, want.blue,
                        got.slot, got.red, got.green, got.blue));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WatchdogLimit) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : run_phases
        int p;
        int start;
        // directed: extremes, every form, ESC, fourth blue digit, terminating byte,
        // large index, over-long red, 21; pairs with a skipped pair
        push_byte(ChEsc);
        push_text("]10;rgb:f/00/fff");
        push_byte(ChEsc);
        push_text("]11;#FFffFF");
        push_byte(ChEsc);
        push_text("]4;15;rgb:0/FFFF/aBcD9");
        push_byte(ChEsc);
        push_text("]4;00;#FF0080");
        push_byte(ChEsc);
        push_text("]4;99;#123456");
        push_byte(ChEsc);
        push_text("]4;1;rgb:12345/1/1");
        push_byte(ChEsc);
        push_text("]21;x=1;background=rgb:1/22/333;foreground=#0a0B0c;");

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            start = bytes_queued;
            while (bytes_queued - start < PhaseBytes) begin
                if ($urandom_range(99) < 85) push_sequence();
                else push_noise();
            end
            if (p == 3) begin
                // pending blue finished by the last byte, then bytes the stopped parser drops
                push_byte(ChEsc);
                push_text("]11;rgb:1/2/3");
                pending_bytes.push_back('{"4", 1'b1});
                pending_bytes.push_back('{ChNul, 1'b0});
                pending_bytes.push_back('{ChEsc, 1'b1});
                repeat (8) pending_bytes.push_back('{8'($urandom_range(255)), 1'($urandom_range(1))});
            end
            while (pending_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        end

        stall_pct = 0;
        while (colours_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d reply bytes over four idle/stall mixes, ending with a stop on the last byte.",
                 bytes_sent);
        $display("Checked %0d colour transfers, %0d mismatches.", colours_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> osc_colour_reply_parser_core.f
src/ocrp_pkg.sv
src/ocrp_parser.sv
src/osc_colour_reply_parser_core.sv
src/ocrp_checker.sv
verif/osc_colour_reply_parser_core_tb.sv
